### rtl/core/terminal_text_line_breaker_core_assert.svh
// ----------------------------------------------------------------------------
// terminal text line breaker assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef TERMINAL_TEXT_LINE_BREAKER_CORE_ASSERT_SVH
`define TERMINAL_TEXT_LINE_BREAKER_CORE_ASSERT_SVH

// condition implies consequence in the same cycle
`define TLB_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define TLB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/tlb_pkg.sv
// ----------------------------------------------------------------------------
// tlb_pkg
// types, character codes and helper functions of the text line breaker
// ----------------------------------------------------------------------------
`default_nettype none

package tlb_pkg;

    // sequencer states, one-hot
    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_PROC     = 9'b000000010,
        S_SETUP    = 9'b000000100,
        S_SCAN_RD  = 9'b000001000,
        S_SCAN_CHK = 9'b000010000,
        S_FOUND    = 9'b000100000,
        S_RPL_RD   = 9'b001000000,
        S_RPL_MS   = 9'b010000000,
        S_END      = 9'b100000000
    } state_t;

    // outcome of measuring one byte
    typedef enum logic [1:0] {
        MC_NONE    = 2'd0,
        MC_NEWLINE = 2'd1,
        MC_WRAP    = 2'd2
    } mcode_t;

    // column remainder width, enough for tab stops up to 16
    localparam int COL_MOD_W = 4;

    // per-line measuring state
    typedef struct packed {
        logic [8:0]           col_count;
        logic [COL_MOD_W-1:0] col_mod;
        logic [23:0]          brk;
        logic                 lead;
        logic                 in_esc;
        logic                 mstop;
        logic [1:0]           qpm;
    } meas_t;

    localparam meas_t MEAS_RESET = '0;

    localparam logic [8:0] COL_MAX = 9'd511;

    // quote prefix tracking codes
    localparam logic [1:0] QP_NONE  = 2'd0;
    localparam logic [1:0] QP_COLON = 2'd1;
    localparam logic [1:0] QP_QUOTE = 2'd2;
    localparam logic [1:0] QP_NO    = 2'd3;

    // line type codes
    localparam logic [1:0] LT_PLAIN_NL   = 2'd0;
    localparam logic [1:0] LT_PLAIN_WRAP = 2'd1;
    localparam logic [1:0] LT_QUOTE_NL   = 2'd2;
    localparam logic [1:0] LT_QUOTE_WRAP = 2'd3;

    // character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_HIGH  = 8'h80;

    localparam logic [7:0] LINE_WIDTH_RESET = 8'd80;
    localparam logic [7:0] LINE_WIDTH_MIN   = 8'd2;

    // escape letters that stop measuring
    function automatic logic is_final_letter(input logic [7:0] c);
        logic r;
        unique case (c)
            "s", "u", "H", "M", "f", "L", "@", "P",
            "A", "B", "C", "D", "J", "K": r = 1'b1;
            default:                     r = 1'b0;
        endcase
        return r;
    endfunction

    // characters that keep an escape sequence open
    function automatic logic is_param_char(input logic [7:0] c);
        logic r;
        unique case (c)
            "[", "0", "1", "2", "3", "4", "5", "6",
            "7", "8", "9", ";", ",": r = 1'b1;
            default:                r = 1'b0;
        endcase
        return r;
    endfunction

    // type of an emitted line from the previous type, length, quote prefix and newline flag
    function automatic logic [1:0] line_type_of(input logic [1:0]  prev,
                                                input logic [23:0] len,
                                                input logic [1:0]  qpm,
                                                input logic        nl);
        logic quote;
        if (prev == LT_PLAIN_WRAP)
            quote = 1'b0;
        else if (prev == LT_QUOTE_WRAP)
            quote = 1'b1;
        else
            quote = (len >= 24'd2) && (qpm == QP_QUOTE);
        return {quote, ~nl};
    endfunction

endpackage

`default_nettype wire

### rtl/core/tlb_measure.sv
// ----------------------------------------------------------------------------
// tlb_measure
// shared column measuring unit: applies one byte to the line state
// ----------------------------------------------------------------------------
`default_nettype none

module tlb_measure #(
    parameter int TAB_STOP = 8
) (
    input  wire logic [7:0]     c,
    input  wire logic [23:0]    pos_in_line,
    input  wire logic           allow_wrap,
    input  wire logic [7:0]     eff_width,
    input  wire tlb_pkg::meas_t st_in,
    output tlb_pkg::meas_t      st_out,
    output tlb_pkg::mcode_t     code,
    output logic [23:0]         wrap_point
);

    localparam int SAT_MOD = 511 % TAB_STOP;

    logic [9:0] tab_col;
    logic       printable;

    assign tab_col   = {1'b0, st_in.col_count} + 10'(TAB_STOP) - 10'(st_in.col_mod);
    assign printable = (c >= tlb_pkg::CH_HIGH)
                     || ((c >= tlb_pkg::CH_SPACE) && (c <= tlb_pkg::CH_TILDE));

    // byte classification and state update
    always_comb
    begin
        st_out     = st_in;
        code       = tlb_pkg::MC_NONE;
        wrap_point = 24'd0;
        // quote prefix on the first two bytes
        if (pos_in_line == 24'd0)
            st_out.qpm = (c == tlb_pkg::CH_COLON) ? tlb_pkg::QP_COLON : tlb_pkg::QP_NO;
        else if (pos_in_line == 24'd1)
            st_out.qpm = ((st_in.qpm == tlb_pkg::QP_COLON) && (c == tlb_pkg::CH_SPACE))
                       ? tlb_pkg::QP_QUOTE : tlb_pkg::QP_NO;

        if (c == tlb_pkg::CH_LF)
        begin
            code = tlb_pkg::MC_NEWLINE;
        end
        else if (st_in.mstop)
        begin
            st_out.mstop = 1'b1;
        end
        else if (c == tlb_pkg::CH_TAB)
        begin
            st_out.lead = 1'b0;
            st_out.brk  = pos_in_line;
            if (tab_col > {1'b0, tlb_pkg::COL_MAX})
            begin
                st_out.col_count = tlb_pkg::COL_MAX;
                st_out.col_mod   = tlb_pkg::COL_MOD_W'(SAT_MOD);
            end
            else
            begin
                st_out.col_count = tab_col[8:0];
                st_out.col_mod   = '0;
            end
        end
        else if (c == tlb_pkg::CH_ESC)
        begin
            st_out.lead   = 1'b0;
            st_out.in_esc = 1'b1;
            st_out.brk    = (pos_in_line != 24'd0) ? pos_in_line - 24'd1 : 24'd0;
        end
        else if (st_in.in_esc)
        begin
            if (tlb_pkg::is_final_letter(c))
                st_out.mstop = 1'b1;
            else if (!tlb_pkg::is_param_char(c))
                st_out.in_esc = 1'b0;
        end
        else if (printable)
        begin
            if (allow_wrap && (st_in.col_count >= {1'b0, eff_width}))
            begin
                code = tlb_pkg::MC_WRAP;
                if (st_in.lead)
                    wrap_point = (pos_in_line != 24'd0) ? pos_in_line - 24'd1 : 24'd0;
                else if (c == tlb_pkg::CH_SPACE)
                    wrap_point = pos_in_line;
                else if (st_in.brk != 24'd0)
                    wrap_point = st_in.brk + 24'd1;
                else
                    wrap_point = pos_in_line;
            end
            else
            begin
                // double-byte pairs and blanks as break candidates
                if (!st_in.lead)
                begin
                    if (c >= tlb_pkg::CH_HIGH)
                        st_out.lead = 1'b1;
                    else if (c == tlb_pkg::CH_SPACE)
                        st_out.brk = pos_in_line;
                end
                else
                begin
                    st_out.lead = 1'b0;
                    st_out.brk  = pos_in_line;
                end
                if (st_in.col_count < tlb_pkg::COL_MAX)
                begin
                    st_out.col_count = st_in.col_count + 9'd1;
                    st_out.col_mod   = (st_in.col_mod == tlb_pkg::COL_MOD_W'(TAB_STOP - 1))
                                     ? '0 : st_in.col_mod + tlb_pkg::COL_MOD_W'(1);
                end
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/terminal_text_line_breaker_core.sv
// ----------------------------------------------------------------------------
// terminal_text_line_breaker_core
// splits a byte stream of text into display line records
// ----------------------------------------------------------------------------
// Text bytes enter on the s_ stream, one beat per byte, s_tlast on the final
// byte of a text. Line records leave on the m_ stream, m_tlast on the last
// record of a text. cfg_ sets the terminal width and is always ready; write
// it only while the block is idle.
// A plain byte is accepted and stored in the line buffer, then passed
// through the measuring unit. A wrap adds a setup step, then a read and a
// check per buffer byte scanned for the next non-blank; when one is found,
// a step emits the record and each byte replayed through the measuring
// unit takes a read and a measuring step, since every look at the line
// buffer is a registered single-port read. The final byte of a text adds an end step.
// A record is registered at the end of the cycle that closes its line; a
// newline record is closed in the measuring step of its byte.
// Results sit in a single output register; while a record waits there, the
// measuring step of the next byte and any further record wait for it.
// Reset empties the output, sets width 80 and starts a new text at offset
// 0; the line buffer needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module terminal_text_line_breaker_core #(
    parameter int LINE_BUFFER_DEPTH = 1024,
    parameter int TAB_STOP          = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // text in, tdata: text_byte[7:0]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        s_tlast,
    // records out, tdata: line_start[23:0], line_length[47:24], line_advance[71:48]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,
    // tuser: line_type[1:0]
    output logic [1:0]       m_tuser,
    output logic             m_tlast,
    // terminal width
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data
);

`include "terminal_text_line_breaker_core_assert.svh"

    localparam int AW      = $clog2(LINE_BUFFER_DEPTH);
    localparam int W24_MOD = (1 << 24) % LINE_BUFFER_DEPTH;

    // line buffer
    logic [7:0] mem [LINE_BUFFER_DEPTH];

    tlb_pkg::state_t state_reg, state_next;
    logic [7:0]      line_width_reg, line_width_next;
    logic [23:0]     line_begin_reg, line_begin_next;
    logic [23:0]     byte_pos_reg, byte_pos_next;
    logic [AW-1:0]   wr_idx_reg, wr_idx_next;
    tlb_pkg::meas_t  meas_reg, meas_next;
    logic            blank_skip_reg, blank_skip_next;
    logic [1:0]      prev_type_reg, prev_type_next;
    logic            done_reg, done_next;
    logic            out_valid_reg, out_valid_next;

    logic [7:0]      c_reg, c_next;
    logic            end_reg, end_next;
    logic [23:0]     pos_reg, pos_next;
    logic [AW-1:0]   pos_idx_reg, pos_idx_next;
    logic [23:0]     rel_reg, rel_next;
    logic [23:0]     b_reg, b_next;
    logic [23:0]     j_reg, j_next;
    logic [23:0]     abs_reg, abs_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [23:0]     rp_i_reg, rp_i_next;
    logic [23:0]     rp_last_reg, rp_last_next;
    logic [7:0]      rd_data_reg;
    logic [23:0]     out_start_reg, out_start_next;
    logic [23:0]     out_len_reg, out_len_next;
    logic [23:0]     out_adv_reg, out_adv_next;
    logic [1:0]      out_type_reg, out_type_next;
    logic            out_fin_reg, out_fin_next;

    logic            in_fire;
    logic            emit_en;
    logic [23:0]     emit_len;
    logic [23:0]     emit_adv;
    logic            emit_nl;
    logic            emit_fin;
    logic [1:0]      emit_qpm;
    logic [1:0]      emit_type;
    logic            text_clear;

    logic [7:0]      m_c;
    logic [23:0]     m_i;
    logic            m_allow;
    logic [7:0]      eff_width;
    tlb_pkg::meas_t  m_st_in, m_st_out;
    tlb_pkg::mcode_t m_code;
    logic [23:0]     m_wp;

    logic [23:0]     brk_dist;
    logic [AW:0]     dist_n;
    logic [AW:0]     back_n;
    logic [AW:0]     idx0;
    logic [23:0]     end_len;
    logic            end_need;
    logic            rd_blank;
    logic            c_blank;
    logic            scan_busy;
    logic            text_at_zero;

    // buffer index of the byte after absolute offset a
    function automatic logic [AW-1:0] idx_step(input logic [23:0]   a,
                                               input logic [AW-1:0] ix);
        logic [AW-1:0] r;
        if (a == 24'hFFFFFF)
            r = '0;
        else if (ix == AW'(LINE_BUFFER_DEPTH - 1))
            r = '0;
        else
            r = ix + AW'(1);
        return r;
    endfunction

    // handshakes
    assign s_tready  = (state_reg == tlb_pkg::S_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {out_adv_reg, out_len_reg, out_start_reg};
    assign m_tuser   = out_type_reg;
    assign m_tlast   = out_fin_reg;

    // measuring unit input selection
    assign eff_width = (line_width_reg < tlb_pkg::LINE_WIDTH_MIN)
                     ? tlb_pkg::LINE_WIDTH_MIN : line_width_reg;
    assign m_c       = (state_reg == tlb_pkg::S_RPL_MS) ? rd_data_reg : c_reg;
    assign m_i       = (state_reg == tlb_pkg::S_RPL_MS) ? rp_i_reg
                     : (blank_skip_reg ? 24'd0 : rel_reg);
    assign m_allow   = (state_reg != tlb_pkg::S_RPL_MS);
    assign m_st_in   = ((state_reg == tlb_pkg::S_PROC) && blank_skip_reg)
                     ? tlb_pkg::MEAS_RESET : meas_reg;

    tlb_measure #(
        .TAB_STOP (TAB_STOP)
    ) u_measure (
        .c           (m_c),
        .pos_in_line (m_i),
        .allow_wrap  (m_allow),
        .eff_width   (eff_width),
        .st_in       (m_st_in),
        .st_out      (m_st_out),
        .code        (m_code),
        .wrap_point  (m_wp)
    );

    // scan start index, the break point lies less than a buffer behind
    assign brk_dist = rel_reg - b_reg;
    assign dist_n   = brk_dist[AW:0];
    assign back_n   = dist_n - {1'b0, pos_reg[AW-1:0]};
    always_comb
    begin
        if (pos_reg >= brk_dist)
            idx0 = ({1'b0, pos_idx_reg} >= dist_n)
                 ? {1'b0, pos_idx_reg} - dist_n
                 : {1'b0, pos_idx_reg} + (AW+1)'(LINE_BUFFER_DEPTH) - dist_n;
        else
            idx0 = ((AW+1)'(W24_MOD) >= back_n)
                 ? (AW+1)'(W24_MOD) - back_n
                 : (AW+1)'(W24_MOD) + (AW+1)'(LINE_BUFFER_DEPTH) - back_n;
    end

    assign rd_blank = (rd_data_reg == tlb_pkg::CH_SPACE) || (rd_data_reg == tlb_pkg::CH_TAB);
    assign c_blank  = (c_reg == tlb_pkg::CH_SPACE) || (c_reg == tlb_pkg::CH_TAB);
    assign end_len  = byte_pos_reg - line_begin_reg;
    assign end_need = !done_reg && !blank_skip_reg && (end_len != 24'd0);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        line_width_next = cfg_valid ? cfg_data : line_width_reg;
        line_begin_next = line_begin_reg;
        byte_pos_next   = byte_pos_reg;
        wr_idx_next     = wr_idx_reg;
        meas_next       = meas_reg;
        blank_skip_next = blank_skip_reg;
        done_next       = done_reg;
        c_next          = c_reg;
        end_next        = end_reg;
        pos_next        = pos_reg;
        pos_idx_next    = pos_idx_reg;
        rel_next        = rel_reg;
        b_next          = b_reg;
        j_next          = j_reg;
        abs_next        = abs_reg;
        idx_next        = idx_reg;
        rp_i_next       = rp_i_reg;
        rp_last_next    = rp_last_reg;
        emit_en         = 1'b0;
        emit_len        = 24'd0;
        emit_adv        = 24'd0;
        emit_nl         = 1'b0;
        emit_fin        = 1'b0;
        emit_qpm        = meas_reg.qpm;
        text_clear      = 1'b0;

        unique case (state_reg)
            tlb_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    c_next        = s_tdata;
                    end_next      = s_tlast;
                    pos_next      = byte_pos_reg;
                    pos_idx_next  = wr_idx_reg;
                    rel_next      = byte_pos_reg - line_begin_reg;
                    byte_pos_next = byte_pos_reg + 24'd1;
                    wr_idx_next   = idx_step(byte_pos_reg, wr_idx_reg);
                    done_next     = 1'b0;
                    state_next    = tlb_pkg::S_PROC;
                end
            end
            tlb_pkg::S_PROC:
            begin
                if (!out_valid_reg)
                begin
                    state_next = end_reg ? tlb_pkg::S_END : tlb_pkg::S_IDLE;
                    if (blank_skip_reg)
                    begin
                        // pending wrap, skipping blanks
                        if (c_blank)
                        begin
                            if (end_reg)
                            begin
                                emit_en   = 1'b1;
                                emit_len  = meas_reg.brk;
                                emit_adv  = rel_reg + 24'd1;
                                emit_fin  = 1'b1;
                                done_next = 1'b1;
                            end
                        end
                        else if (c_reg == tlb_pkg::CH_LF)
                        begin
                            emit_en         = 1'b1;
                            emit_len        = meas_reg.brk;
                            emit_adv        = rel_reg + 24'd1;
                            emit_nl         = 1'b1;
                            emit_fin        = end_reg;
                            done_next       = end_reg;
                            blank_skip_next = 1'b0;
                            line_begin_next = pos_reg + 24'd1;
                            meas_next       = tlb_pkg::MEAS_RESET;
                        end
                        else
                        begin
                            emit_en         = 1'b1;
                            emit_len        = meas_reg.brk;
                            emit_adv        = rel_reg;
                            blank_skip_next = 1'b0;
                            line_begin_next = pos_reg;
                            meas_next       = m_st_out;
                        end
                    end
                    else
                    begin
                        meas_next = m_st_out;
                        unique case (m_code)
                            tlb_pkg::MC_NEWLINE:
                            begin
                                emit_en         = 1'b1;
                                emit_len        = rel_reg;
                                emit_adv        = rel_reg + 24'd1;
                                emit_nl         = 1'b1;
                                emit_fin        = end_reg;
                                emit_qpm        = m_st_out.qpm;
                                done_next       = end_reg;
                                line_begin_next = pos_reg + 24'd1;
                                meas_next       = tlb_pkg::MEAS_RESET;
                            end
                            tlb_pkg::MC_WRAP:
                            begin
                                // break beyond the buffer falls back to this byte
                                if ((m_wp > rel_reg)
                                    || ((rel_reg - m_wp) >= 24'(LINE_BUFFER_DEPTH)))
                                    b_next = rel_reg;
                                else
                                    b_next = m_wp;
                                state_next = tlb_pkg::S_SETUP;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            tlb_pkg::S_SETUP:
            begin
                j_next     = b_reg;
                abs_next   = line_begin_reg + b_reg;
                idx_next   = idx0[AW-1:0];
                state_next = tlb_pkg::S_SCAN_RD;
            end
            tlb_pkg::S_SCAN_RD:
            begin
                state_next = tlb_pkg::S_SCAN_CHK;
            end
            tlb_pkg::S_SCAN_CHK:
            begin
                if (!rd_blank)
                begin
                    state_next = tlb_pkg::S_FOUND;
                end
                else if (j_reg == rel_reg)
                begin
                    // only blanks after the break, enter blank skip
                    if (!(end_reg && out_valid_reg))
                    begin
                        blank_skip_next = 1'b1;
                        meas_next.brk   = b_reg;
                        if (end_reg)
                        begin
                            emit_en   = 1'b1;
                            emit_len  = b_reg;
                            emit_adv  = rel_reg + 24'd1;
                            emit_fin  = 1'b1;
                            done_next = 1'b1;
                        end
                        state_next = end_reg ? tlb_pkg::S_END : tlb_pkg::S_IDLE;
                    end
                end
                else
                begin
                    j_next     = j_reg + 24'd1;
                    abs_next   = abs_reg + 24'd1;
                    idx_next   = idx_step(abs_reg, idx_reg);
                    state_next = tlb_pkg::S_SCAN_RD;
                end
            end
            tlb_pkg::S_FOUND:
            begin
                if (!out_valid_reg)
                begin
                    emit_en         = 1'b1;
                    emit_len        = b_reg;
                    emit_adv        = j_reg;
                    line_begin_next = abs_reg;
                    meas_next       = tlb_pkg::MEAS_RESET;
                    rp_i_next       = 24'd0;
                    rp_last_next    = rel_reg - j_reg;
                    state_next      = tlb_pkg::S_RPL_RD;
                end
            end
            tlb_pkg::S_RPL_RD:
            begin
                state_next = tlb_pkg::S_RPL_MS;
            end
            tlb_pkg::S_RPL_MS:
            begin
                meas_next = m_st_out;
                if (rp_i_reg == rp_last_reg)
                begin
                    state_next = end_reg ? tlb_pkg::S_END : tlb_pkg::S_IDLE;
                end
                else
                begin
                    rp_i_next  = rp_i_reg + 24'd1;
                    abs_next   = abs_reg + 24'd1;
                    idx_next   = idx_step(abs_reg, idx_reg);
                    state_next = tlb_pkg::S_RPL_RD;
                end
            end
            tlb_pkg::S_END:
            begin
                // flush the open line and start a new text
                if (!(end_need && out_valid_reg))
                begin
                    if (end_need)
                    begin
                        emit_en  = 1'b1;
                        emit_len = end_len;
                        emit_adv = end_len;
                        emit_fin = 1'b1;
                    end
                    text_clear      = 1'b1;
                    line_begin_next = 24'd0;
                    byte_pos_next   = 24'd0;
                    wr_idx_next     = '0;
                    meas_next       = tlb_pkg::MEAS_RESET;
                    blank_skip_next = 1'b0;
                    state_next      = tlb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tlb_pkg::S_IDLE;
            end
        endcase
    end

    // record assembly into the output register
    assign emit_type = tlb_pkg::line_type_of(prev_type_reg, emit_len, emit_qpm, emit_nl);

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_start_next = out_start_reg;
        out_len_next   = out_len_reg;
        out_adv_next   = out_adv_reg;
        out_type_next  = out_type_reg;
        out_fin_next   = out_fin_reg;
        prev_type_next = prev_type_reg;
        if (emit_en)
        begin
            out_valid_next = 1'b1;
            out_start_next = line_begin_reg;
            out_len_next   = emit_len;
            out_adv_next   = emit_adv;
            out_type_next  = emit_type;
            out_fin_next   = emit_fin;
            prev_type_next = emit_type;
        end
        if (text_clear)
            prev_type_next = tlb_pkg::LT_PLAIN_NL;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tlb_pkg::S_IDLE;
            line_width_reg <= tlb_pkg::LINE_WIDTH_RESET;
            line_begin_reg <= 24'd0;
            byte_pos_reg   <= 24'd0;
            wr_idx_reg     <= '0;
            meas_reg       <= tlb_pkg::MEAS_RESET;
            blank_skip_reg <= 1'b0;
            prev_type_reg  <= tlb_pkg::LT_PLAIN_NL;
            done_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            line_width_reg <= line_width_next;
            line_begin_reg <= line_begin_next;
            byte_pos_reg   <= byte_pos_next;
            wr_idx_reg     <= wr_idx_next;
            meas_reg       <= meas_next;
            blank_skip_reg <= blank_skip_next;
            prev_type_reg  <= prev_type_next;
            done_reg       <= done_next;
            out_valid_reg  <= out_valid_next;
            idx_reg        <= idx_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        c_reg         <= c_next;
        end_reg       <= end_next;
        pos_reg       <= pos_next;
        pos_idx_reg   <= pos_idx_next;
        rel_reg       <= rel_next;
        b_reg         <= b_next;
        j_reg         <= j_next;
        abs_reg       <= abs_next;
        rp_i_reg      <= rp_i_next;
        rp_last_reg   <= rp_last_next;
        out_start_reg <= out_start_next;
        out_len_reg   <= out_len_next;
        out_adv_reg   <= out_adv_next;
        out_type_reg  <= out_type_next;
        out_fin_reg   <= out_fin_next;
    end

    // line buffer write on accept, registered read
    always_ff @(posedge clk)
    begin
        if (in_fire)
            mem[wr_idx_reg] <= s_tdata;
        rd_data_reg <= mem[idx_reg];
    end

    // checks
    assign scan_busy    = (state_reg == tlb_pkg::S_SCAN_RD) || (state_reg == tlb_pkg::S_SCAN_CHK);
    assign text_at_zero = (byte_pos_reg == 24'd0) && !blank_skip_reg
                        && (line_begin_reg == 24'd0);

    `TLB_ASSERT_IMPLY(a_emit_free, emit_en, !out_valid_reg, "record overwrote a pending beat")
    `TLB_ASSERT_IMPLY(a_scan_bound, scan_busy, j_reg <= rel_reg, "scan ran past the byte")
    `TLB_ASSERT_NEXT(a_text_clear, text_clear, text_at_zero, "text state not cleared")

endmodule

`default_nettype wire
